// ===== rtl/sawrs_pkg.sv =====
// Package for the stop-and-wait request sender: types, phase codes,
// register indexes and reset values. No dependencies.
package sawrs_pkg;

    // Default parameter values
    localparam int MAX_PAYLOAD_DEF  = 1024;
    localparam int HEADER_BYTES_DEF = 16;
    localparam int MAC_BYTES_DEF    = 16;
    localparam int US_PER_MS_DEF    = 1000;
    localparam int SEQ_BITS_DEF     = 32;

    // Configuration port
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;

    localparam logic [CFG_IDX_W-1:0] CFG_SEND_TYPE      = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ACK_TYPE       = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_NACK_TYPE      = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_NEEDS_ACK      = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_PKT_INTERVAL   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_RETX       = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_RETX_TIMEOUT   = 3'd6;

    // Register reset values
    localparam logic [7:0]  RST_SEND_TYPE    = 8'd0;
    localparam logic [7:0]  RST_ACK_TYPE     = 8'd0;
    localparam logic [7:0]  RST_NACK_TYPE    = 8'd0;
    localparam logic        RST_NEEDS_ACK    = 1'b1;
    localparam logic [31:0] RST_PKT_INTERVAL = 32'd100000;
    localparam logic [7:0]  RST_MAX_RETX     = 8'd5;
    localparam logic [15:0] RST_RETX_TIMEOUT = 16'd1000;

    // Top three bits of a type byte select its class
    localparam logic [7:0] TYPE_CLASS_MASK = 8'he0;

    // Received message status codes
    localparam logic [1:0] RX_NONE     = 2'd0;
    localparam logic [1:0] RX_VALID    = 2'd1;
    localparam logic [1:0] RX_REPEATED = 2'd2;
    localparam logic [1:0] RX_USED     = 2'd3;

    localparam int PHASE_W = 3;

    typedef enum logic [PHASE_W-1:0] {
        PH_IDLE   = 3'd0,
        PH_ENCODE = 3'd1,
        PH_SEND   = 3'd2,
        PH_WAIT   = 3'd3,
        PH_VERIFY = 3'd4
    } t_phase;

    typedef struct packed {
        logic [63:0] now_us;
        logic [10:0] payload_length;
        logic [1:0]  rx_status;
        logic [7:0]  rx_type;
        logic [31:0] rx_ack_seq;
        logic        rx_mac_ok;
    } t_in_item;

    typedef struct packed {
        logic [PHASE_W-1:0] next_phase;
        logic               consume_rx;
        logic               encode_now;
        logic [31:0]        seq_out;
        logic               transmit_now;
        logic [10:0]        send_length;
        logic               clear_session;
    } t_result;

    // Register file contents; timeout_thr_us is (timeout_ms + 1) * US_PER_MS
    typedef struct packed {
        logic [7:0]  send_type;
        logic [7:0]  ack_type;
        logic [7:0]  nack_type;
        logic        needs_ack;
        logic [31:0] packet_interval_us;
        logic [7:0]  max_retransmissions;
        logic [63:0] timeout_thr_us;
    } t_cfg;

endpackage

// ===== rtl/stop_and_wait_request_sender_top.sv =====
// Top level of the stop-and-wait request sender: input register, result register
// and the configuration and sequencer blocks. Depends on sawrs_pkg, sawrs_cfg, sawrs_ctrl.
//
// One input item is one controller step of a stop-and-wait ARQ transmitter and gives
// exactly one result item. An item is captured in an input register, passes through the
// phase sequencer (idle, encode, send, wait, verify) and lands in a result register, so
// the block takes one item per clock cycle while the consumer does not stall the result
// register. Its result is loaded into the result register as the item leaves the input
// register and is held there until taken. The rate is set by the single sequencer pass,
// whose session state (sequence number, send count, last send time, send length)
// advances as each item leaves the input register. Input ready drops only when the input
// register is full and the result register is held by a stalled consumer. Configuration
// writes are always taken, one per cycle; write them only while no item is in flight. The
// retransmit timeout is turned into a microsecond threshold when it is written.
module stop_and_wait_request_sender_top #(
    parameter int MAX_PAYLOAD  = sawrs_pkg::MAX_PAYLOAD_DEF,
    parameter int HEADER_BYTES = sawrs_pkg::HEADER_BYTES_DEF,
    parameter int MAC_BYTES    = sawrs_pkg::MAC_BYTES_DEF,
    parameter int US_PER_MS    = sawrs_pkg::US_PER_MS_DEF,
    parameter int SEQ_BITS     = sawrs_pkg::SEQ_BITS_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    // configuration write channel
    input  logic                             i_cfg_valid,
    output logic                             o_cfg_ready,
    input  logic [sawrs_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [sawrs_pkg::CFG_DATA_W-1:0] i_cfg_data,
    // input item channel
    input  logic                             i_in_valid,
    output logic                             o_in_ready,
    input  logic [63:0]                      i_now_us,
    input  logic [10:0]                      i_payload_length,
    input  logic [1:0]                       i_rx_status,
    input  logic [7:0]                       i_rx_type,
    input  logic [31:0]                      i_rx_ack_seq,
    input  logic                             i_rx_mac_ok,
    // result item channel
    output logic                             o_out_valid,
    input  logic                             i_out_ready,
    output logic [2:0]                       o_next_phase,
    output logic                             o_consume_rx,
    output logic                             o_encode_now,
    output logic [31:0]                      o_seq_out,
    output logic                             o_transmit_now,
    output logic [10:0]                      o_send_length,
    output logic                             o_clear_session
);
    import sawrs_pkg::*;

    t_cfg     cfg;
    t_in_item r_item;
    t_result  step_res, r_res;
    logic     r_in_valid, r_out_valid;
    logic     advance;

    // Move the held item into the result register when that register is free or draining
    assign advance     = r_in_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready  = !r_in_valid || advance;
    assign o_cfg_ready = 1'b1;

    sawrs_cfg #(
        .US_PER_MS(US_PER_MS)
    ) u_cfg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_valid(i_cfg_valid),
        .i_cfg_index(i_cfg_index),
        .i_cfg_data (i_cfg_data),
        .o_cfg      (cfg)
    );

    sawrs_ctrl #(
        .MAX_PAYLOAD (MAX_PAYLOAD),
        .HEADER_BYTES(HEADER_BYTES),
        .MAC_BYTES   (MAC_BYTES),
        .SEQ_BITS    (SEQ_BITS)
    ) u_ctrl (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_step (advance),
        .i_item (r_item),
        .i_cfg  (cfg),
        .o_res  (step_res)
    );

    // Input register: valid bit under reset, payload captured on acceptance
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && o_in_ready) begin
            r_item.now_us         <= i_now_us;
            r_item.payload_length <= i_payload_length;
            r_item.rx_status      <= i_rx_status;
            r_item.rx_type        <= i_rx_type;
            r_item.rx_ack_seq     <= i_rx_ack_seq;
            r_item.rx_mac_ok      <= i_rx_mac_ok;
        end
    end

    // Result register: hold until taken, load on advance
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_res <= step_res;
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_next_phase    = r_res.next_phase;
    assign o_consume_rx    = r_res.consume_rx;
    assign o_encode_now    = r_res.encode_now;
    assign o_seq_out       = r_res.seq_out;
    assign o_transmit_now  = r_res.transmit_now;
    assign o_send_length   = r_res.send_length;
    assign o_clear_session = r_res.clear_session;

`ifndef SYNTHESIS
    // An encode step always hands over to send
    a_encode_to_send: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && o_encode_now) |-> (o_next_phase == PH_SEND))
        else $error("encode step did not move to send");

    // Clearing the session sends nothing and drops back to idle
    a_clear_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && o_clear_session) |-> (!o_transmit_now && (o_next_phase == PH_IDLE)))
        else $error("clear_session with transmit or without idle");

    // A transmission ends in wait or idle, never elsewhere
    a_transmit_next: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && o_transmit_now)
            |-> ((o_next_phase == PH_WAIT) || (o_next_phase == PH_IDLE)))
        else $error("transmit step left to an unexpected phase");

    // A result loaded while the consumer stalls must not be overwritten
    a_no_overrun: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !i_out_ready) |=> (r_out_valid && $stable(r_res)))
        else $error("result register overwritten before it was taken");
`endif

endmodule

// ===== rtl/sawrs_cfg.sv =====
// Configuration register file of the stop-and-wait request sender.
// Depends on sawrs_pkg.
module sawrs_cfg #(
    parameter int US_PER_MS = sawrs_pkg::US_PER_MS_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_valid,
    input  logic [sawrs_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [sawrs_pkg::CFG_DATA_W-1:0] i_cfg_data,
    output sawrs_pkg::t_cfg                  o_cfg
);
    import sawrs_pkg::*;

    localparam int UW   = $clog2(US_PER_MS + 1);
    localparam int THRW = 17 + UW;
    localparam logic [63:0] THR_RESET =
        64'((THRW'(RST_RETX_TIMEOUT) + THRW'(1)) * THRW'(US_PER_MS));

    t_cfg        r_cfg;
    logic [16:0] timeout_inc;
    logic [63:0] n_thr;

    // Precompute the elapsed-time threshold so the timeout test is a single compare
    assign timeout_inc = {1'b0, i_cfg_data[15:0]} + 17'd1;
    assign n_thr       = 64'(THRW'(timeout_inc) * THRW'(US_PER_MS));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.send_type           <= RST_SEND_TYPE;
            r_cfg.ack_type            <= RST_ACK_TYPE;
            r_cfg.nack_type           <= RST_NACK_TYPE;
            r_cfg.needs_ack           <= RST_NEEDS_ACK;
            r_cfg.packet_interval_us  <= RST_PKT_INTERVAL;
            r_cfg.max_retransmissions <= RST_MAX_RETX;
            r_cfg.timeout_thr_us      <= THR_RESET;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_SEND_TYPE:    r_cfg.send_type           <= i_cfg_data[7:0];
                CFG_ACK_TYPE:     r_cfg.ack_type            <= i_cfg_data[7:0];
                CFG_NACK_TYPE:    r_cfg.nack_type           <= i_cfg_data[7:0];
                CFG_NEEDS_ACK:    r_cfg.needs_ack           <= i_cfg_data[0];
                CFG_PKT_INTERVAL: r_cfg.packet_interval_us  <= i_cfg_data[31:0];
                CFG_MAX_RETX:     r_cfg.max_retransmissions <= i_cfg_data[7:0];
                CFG_RETX_TIMEOUT: r_cfg.timeout_thr_us      <= n_thr;
                default: begin
                end
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

// ===== rtl/sawrs_ctrl.sv =====
// Phase sequencer and session state of the stop-and-wait request sender.
// Depends on sawrs_pkg.
module sawrs_ctrl #(
    parameter int MAX_PAYLOAD  = sawrs_pkg::MAX_PAYLOAD_DEF,
    parameter int HEADER_BYTES = sawrs_pkg::HEADER_BYTES_DEF,
    parameter int MAC_BYTES    = sawrs_pkg::MAC_BYTES_DEF,
    parameter int SEQ_BITS     = sawrs_pkg::SEQ_BITS_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_step,
    input  sawrs_pkg::t_in_item i_item,
    input  sawrs_pkg::t_cfg     i_cfg,
    output sawrs_pkg::t_result  o_res
);
    import sawrs_pkg::*;

    localparam int CW = (SEQ_BITS > 32) ? SEQ_BITS : 32;
    localparam int LW = 18;

    t_phase              r_phase, n_phase;
    logic [SEQ_BITS-1:0] r_seq, n_seq;
    logic [7:0]          r_tx_count, n_tx_count;
    logic [63:0]         r_last_send, n_last_send;
    logic [10:0]         r_msg_len, n_msg_len;

    logic        rx_valid, rx_fresh, same_class, rate_hold, timed_out;
    logic        seq_match, at_limit;
    logic [63:0] elapsed;
    logic [LW-1:0] plen_clamped, len_sum;
    logic        consume, encode, transmit, clear;

    assign rx_valid   = (i_item.rx_status == RX_VALID);
    assign rx_fresh   = rx_valid || (i_item.rx_status == RX_REPEATED);
    assign same_class = ((i_item.rx_type & TYPE_CLASS_MASK)
                         == (i_cfg.send_type & TYPE_CLASS_MASK));
    assign elapsed    = i_item.now_us - r_last_send;
    assign rate_hold  = !i_cfg.needs_ack && (elapsed <= {32'd0, i_cfg.packet_interval_us});
    assign timed_out  = (elapsed >= i_cfg.timeout_thr_us);
    assign seq_match  = (CW'(r_seq) == CW'(i_item.rx_ack_seq)) && i_item.rx_mac_ok;
    assign at_limit   = (r_tx_count >= i_cfg.max_retransmissions);

    assign plen_clamped = (LW'(i_item.payload_length) > LW'(MAX_PAYLOAD))
                          ? LW'(MAX_PAYLOAD) : LW'(i_item.payload_length);
    assign len_sum      = plen_clamped + LW'(HEADER_BYTES) + LW'(MAC_BYTES);

    // Next phase
    always_comb begin
        n_phase = PH_IDLE;
        case (r_phase)
            PH_IDLE: begin
                if (!rate_hold && (i_item.payload_length != 11'd0)) begin
                    n_phase = PH_ENCODE;
                end
            end
            PH_ENCODE: n_phase = PH_SEND;
            PH_SEND: begin
                if (!at_limit && i_cfg.needs_ack) begin
                    n_phase = PH_WAIT;
                end
            end
            PH_WAIT: begin
                n_phase = PH_WAIT;
                if (timed_out) begin
                    n_phase = PH_SEND;
                end else if (rx_valid && (i_item.rx_type == i_cfg.ack_type)) begin
                    n_phase = PH_VERIFY;
                end else if (rx_valid && (i_item.rx_type == i_cfg.nack_type) && seq_match) begin
                    n_phase = PH_SEND;
                end
            end
            PH_VERIFY: n_phase = seq_match ? PH_IDLE : PH_WAIT;
            default:   n_phase = PH_IDLE;
        endcase
    end

    // Flags and session state updates
    always_comb begin
        consume     = 1'b0;
        encode      = 1'b0;
        transmit    = 1'b0;
        clear       = 1'b0;
        n_seq       = r_seq;
        n_tx_count  = r_tx_count;
        n_last_send = r_last_send;
        n_msg_len   = r_msg_len;
        case (r_phase)
            PH_IDLE: begin
                consume = rx_fresh && same_class;
                if (!rate_hold && (i_item.payload_length != 11'd0)) begin
                    n_msg_len = len_sum[10:0];
                end
            end
            PH_ENCODE: begin
                n_seq      = r_seq + SEQ_BITS'(1);
                n_tx_count = 8'd0;
                encode     = 1'b1;
            end
            PH_SEND: begin
                if (at_limit) begin
                    clear = 1'b1;
                end else begin
                    transmit    = 1'b1;
                    n_tx_count  = r_tx_count + 8'd1;
                    n_last_send = i_item.now_us;
                end
            end
            PH_WAIT: begin
                if (timed_out) begin
                    consume = 1'b0;
                end else if (rx_valid && (i_item.rx_type == i_cfg.ack_type)) begin
                    consume = 1'b0;
                end else if (rx_valid && (i_item.rx_type == i_cfg.nack_type)) begin
                    consume = 1'b1;
                end else begin
                    consume = rx_fresh && same_class;
                end
            end
            PH_VERIFY: consume = 1'b1;
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_IDLE;
            r_seq       <= '0;
            r_tx_count  <= 8'd0;
            r_last_send <= 64'd0;
            r_msg_len   <= 11'd0;
        end else if (i_step) begin
            r_phase     <= n_phase;
            r_seq       <= n_seq;
            r_tx_count  <= n_tx_count;
            r_last_send <= n_last_send;
            r_msg_len   <= n_msg_len;
        end
    end

    assign o_res.next_phase    = n_phase;
    assign o_res.consume_rx    = consume;
    assign o_res.encode_now    = encode;
    assign o_res.seq_out       = 32'(n_seq);
    assign o_res.transmit_now  = transmit;
    assign o_res.send_length   = n_msg_len;
    assign o_res.clear_session = clear;

endmodule
